// File: rtl/lrg_pkg.sv
`timescale 1ns / 1ps
// Package for the linear ramp generator: item structs, command codes,
// divider handshake types and widths. No dependencies.
package lrg_pkg;

  localparam int REF_W               = 32;           // reference / target width
  localparam int DIFF_W              = REF_W + 1;    // signed difference width
  localparam int CNT_FIELD_W         = 16;           // step_count field width
  localparam int STEP_COUNT_BITS_DEF = 16;           // default steps_left width
  localparam int DIV_ITERS           = REF_W;        // one quotient bit per cycle
  localparam int DIV_ITER_W          = $clog2(DIV_ITERS);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic                    command;
    logic signed [REF_W-1:0] target;
    logic [CNT_FIELD_W-1:0]  step_count;
  } in_item_t;

  typedef struct packed {
    logic signed [REF_W-1:0] reference;
    logic                    ramp_done;
  } out_item_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] diff;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIFF_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/lrg_div.sv
`timescale 1ns / 1ps
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on lrg_pkg.
module lrg_div import lrg_pkg::*; #(
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  div_req_t                   req,
  input  logic [STEP_COUNT_BITS-1:0] divisor,
  output div_rsp_t                   rsp
);

  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [DIV_ITER_W-1:0]      iter_r, iter_nxt;
  logic                       neg_r, neg_nxt;
  logic [REF_W-1:0]           dvd_r, dvd_nxt;   // dividend shifts out, quotient shifts in
  logic [STEP_COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [STEP_COUNT_BITS-1:0] dsr_r, dsr_nxt;

  logic [DIFF_W-1:0]          mag;
  logic [STEP_COUNT_BITS:0]   shifted;
  logic [STEP_COUNT_BITS:0]   trial;
  logic                       ge;
  logic [DIFF_W-1:0]          q_mag;

  assign mag     = req.diff[DIFF_W-1] ? DIFF_W'(-req.diff) : DIFF_W'(req.diff);
  assign shifted = {rem_r, dvd_r[REF_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};
  assign ge      = ~trial[STEP_COUNT_BITS];

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    neg_nxt  = neg_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      run_nxt  = 1'b1;
      iter_nxt = '0;
      neg_nxt  = req.diff[DIFF_W-1];
      dvd_nxt  = mag[REF_W-1:0];   // |diff| < 2^32
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (run_r) begin
      rem_nxt  = ge ? trial[STEP_COUNT_BITS-1:0] : shifted[STEP_COUNT_BITS-1:0];
      dvd_nxt  = {dvd_r[REF_W-2:0], ge};
      iter_nxt = iter_r + 1'b1;
      if (iter_r == DIV_ITER_W'(DIV_ITERS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign q_mag        = {1'b0, dvd_r};
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? DIFF_W'(-q_mag) : q_mag;

endmodule

// File: rtl/linear_ramp_generator_top.sv
`timescale 1ns / 1ps
// Linear ramp generator: ramp state, command handling and result register.
// Latency: every item's result is in out_data the cycle after acceptance.
// Throughput: tick and jump items every cycle while out_ready keeps pace;
// a start with a nonzero count holds in_ready low until the divided increment is stored.
// Reset (synchronous, rst_n low): reference, target, count and increment clear.
// Depends on lrg_pkg and lrg_div.
module linear_ramp_generator_top import lrg_pkg::*; #(
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Ramp state
  logic signed [REF_W-1:0]    cur_ref_r, cur_ref_nxt;
  logic signed [REF_W-1:0]    tgt_r, tgt_nxt;
  logic [STEP_COUNT_BITS-1:0] steps_r, steps_nxt;
  logic signed [DIFF_W-1:0]   inc_r, inc_nxt;

  // Control: busy while the divider works out a new increment
  logic      busy_r, busy_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic                           in_fire;
  logic [STEP_COUNT_BITS+CNT_FIELD_W-1:0] cnt_ext;
  logic [STEP_COUNT_BITS-1:0]     cnt_in;
  div_req_t                       div_req;
  div_rsp_t                       div_rsp;

  // New item only when idle and the result slot frees up this cycle
  assign in_ready = ~busy_r & (~out_valid_r | out_ready);
  assign in_fire  = in_valid & in_ready;

  // step_count is taken modulo 2^STEP_COUNT_BITS
  assign cnt_ext = {{STEP_COUNT_BITS{1'b0}}, in_data.step_count};
  assign cnt_in  = cnt_ext[STEP_COUNT_BITS-1:0];

  // Divider launches straight from an accepted start item with a nonzero count
  assign div_req.start = in_fire & (in_data.command == CMD_START) & (cnt_in != '0);
  assign div_req.diff  = {in_data.target[REF_W-1], in_data.target}
                       - {cur_ref_r[REF_W-1], cur_ref_r};

  lrg_div #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (cnt_in),
    .rsp     (div_rsp)
  );

  always_comb begin
    cur_ref_nxt = cur_ref_r;
    tgt_nxt     = tgt_r;
    steps_nxt   = steps_r;
    inc_nxt     = inc_r;
    busy_nxt    = busy_r;

    if (in_fire) begin
      if (in_data.command == CMD_START) begin
        if (cnt_in == '0) begin
          // jump: target taken at once, stored target untouched
          cur_ref_nxt = in_data.target;
          steps_nxt   = '0;
          inc_nxt     = '0;
        end else begin
          tgt_nxt   = in_data.target;
          steps_nxt = cnt_in;
          busy_nxt  = 1'b1;
        end
      end else begin
        if (steps_r > STEP_COUNT_BITS'(1)) begin
          cur_ref_nxt = cur_ref_r + inc_r[REF_W-1:0];
          steps_nxt   = steps_r - 1'b1;
        end else if (steps_r == STEP_COUNT_BITS'(1)) begin
          // last step snaps to the target, no rounding residue
          cur_ref_nxt = tgt_r;
          steps_nxt   = '0;
        end
      end
    end

    if (div_rsp.done) begin
      inc_nxt  = div_rsp.quotient;
      busy_nxt = 1'b0;
    end
  end

  // Result register: loaded on every accept, the reference does not wait on the divide
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.reference = cur_ref_nxt;
      out_data_nxt.ramp_done = (steps_nxt == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_ref_r   <= '0;
      tgt_r       <= '0;
      steps_r     <= '0;
      inc_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_ref_r   <= cur_ref_nxt;
      tgt_r       <= tgt_nxt;
      steps_r     <= steps_nxt;
      inc_r       <= inc_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Divider result only ever lands while a start is pending
  a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> busy_r)
    else $error("divider finished with no start pending");

  // A ramp start with nonzero count must lock out new items next cycle
  a_start_locks: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> (busy_r && !in_ready))
    else $error("start did not lock the input");

  // Every accepted item leaves a result waiting
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

  // Count only moves on an accepted item
  a_steps_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(steps_r))
    else $error("step count changed without an item");

endmodule

// File: tb/sv/tb_linear_ramp_generator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for linear_ramp_generator_top: directed and random
// ramp items against an in-bench ramp predictor. Depends on lrg_pkg and the RTL.
module tb_linear_ramp_generator_top;
  import lrg_pkg::*;

  localparam int STEP_W       = STEP_COUNT_BITS_DEF;
  localparam int RANDOM_ITEMS = 1050;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 40;    // a bit more than one divide pass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // When set, neither side idles; lets back-to-back stretches happen.
  bit no_idle;
  int mismatch_count;

  // Ramp state as the predictor sees it.
  logic signed [REF_W-1:0]  ramp_ref;
  logic signed [REF_W-1:0]  ramp_tgt;
  logic [STEP_W-1:0]        ramp_steps;
  logic signed [DIFF_W-1:0] ramp_incr;

  out_item_t expected_refs[$];

  linear_ramp_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // Applies one accepted item to the ramp state and returns the result it yields.
  function automatic out_item_t advance_ramp(in_item_t it);
    out_item_t        res;
    logic [STEP_W-1:0] cnt;
    longint           diff;
    cnt = it.step_count;   // count wraps at the steps_left width
    if (it.command == CMD_START) begin
      if (cnt == '0) begin
        // jump: target taken at once, stored target left alone
        ramp_steps = '0;
        ramp_incr  = '0;
        ramp_ref   = it.target;
      end else begin
        diff       = longint'(it.target) - longint'(ramp_ref);
        ramp_tgt   = it.target;
        ramp_steps = cnt;
        ramp_incr  = DIFF_W'(diff / longint'(cnt));   // truncates toward zero
      end
    end else begin
      if (ramp_steps > 1) begin
        ramp_ref   = ramp_ref + ramp_incr[REF_W-1:0];
        ramp_steps = ramp_steps - 1'b1;
      end else if (ramp_steps == 1) begin
        ramp_ref   = ramp_tgt;   // last tick snaps to the target
        ramp_steps = '0;
      end
    end
    res.reference = ramp_ref;
    res.ramp_done = (ramp_steps == '0);
    return res;
  endfunction

  function automatic void log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Sends one item after a random gap; predicts its result on acceptance.
  task automatic send_item(input logic cmd, input logic [REF_W-1:0] tgt,
                           input logic [CNT_FIELD_W-1:0] cnt);
    in_item_t item;
    int       gap;
    item.command    = cmd;
    item.target     = tgt;
    item.step_count = cnt;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_refs.push_back(advance_ramp(item));
  endtask

  task automatic start_ramp(input logic [REF_W-1:0] tgt, input logic [CNT_FIELD_W-1:0] cnt);
    send_item(CMD_START, tgt, cnt);
  endtask

  // Tick fields other than command are don't-care, so fill them with noise.
  task automatic tick();
    send_item(CMD_TICK, $urandom, 16'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_refs.size() != 0) @(posedge clk);
  endtask

  // Ticks straight out of reset: nothing to ramp, reference stays at zero.
  task automatic test_idle_ticks();
    send_item(CMD_TICK, '1, '1);
    send_item(CMD_TICK, '0, '0);
  endtask

  // Zero count jumps to the target at both extremes of the range, at -1 and at zero.
  task automatic test_jumps();
    start_ramp(32'h7FFF_FFFF, '0);
    start_ramp(32'h8000_0000, '0);
    start_ramp(32'hFFFF_FFFF, '0);
    start_ramp(32'h0000_0000, '0);
  endtask

  // Single-step ramp with an extra tick, then a falling ramp whose increment
  // truncates toward zero and a rising ramp whose increment divides exactly.
  task automatic test_short_ramps();
    start_ramp(32'd100, 16'd1);
    tick();
    tick();
    start_ramp(-32'sd10, 16'd3);
    repeat (3) tick();
    start_ramp(32'd10, 16'd4);
    repeat (4) tick();
  endtask

  // Full-scale swing with the largest count, abandoned mid-ramp by a restart.
  task automatic test_full_scale();
    start_ramp(32'h8000_0000, '0);
    start_ramp(32'h7FFF_FFFF, 16'hFFFF);
    tick();
    start_ramp(32'h8000_0000, 16'd2);
    tick();
    tick();
  endtask

  // Either anywhere in range or close to the present reference.
  function automatic logic [REF_W-1:0] pick_target();
    if ($urandom_range(0, 3) == 0) return ramp_ref + ($urandom_range(0, 64) - 32);
    return $urandom;
  endfunction

  // Mostly complete ramps with random content; some jumps, restarts and noise.
  task automatic test_random_ramps();
    int                     sent;
    int                     kind;
    int                     ticks;
    logic [CNT_FIELD_W-1:0] cnt;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      kind    = $urandom_range(0, 9);
      if (kind <= 6) begin
        if ($urandom_range(0, 7) == 0) begin
          cnt   = 16'($urandom);
          ticks = $urandom_range(1, 6);          // long ramp, cut by a restart
        end else begin
          cnt   = 16'($urandom_range(1, 12));
          if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, int'(cnt));
          else ticks = int'(cnt) + $urandom_range(0, 2);
        end
        start_ramp(pick_target(), cnt);
        repeat (ticks) tick();
        sent += 1 + ticks;
      end else if (kind == 7) begin
        start_ramp(pick_target(), '0);
        sent++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(1'($urandom_range(0, 1)), $urandom, 16'($urandom));
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: stall a random number of cycles after each item taken.
  initial begin
    out_ready = 1'b1;
    forever begin : drive_ready
      int stall;
      @(posedge clk);
      if (out_valid && out_ready) begin
        stall = draw_gap();
        if (stall > 0) begin
          @(negedge clk);
          out_ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
          @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Every result taken is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_refs.size() == 0) begin
        log_mismatch($sformatf("unexpected item: reference %0d done %0b",
                               out_data.reference, out_data.ramp_done));
      end else begin
        want = expected_refs.pop_front();
        if (out_data.reference !== want.reference)
          log_mismatch($sformatf("reference mismatch: expected %0d got %0d",
                                 want.reference, out_data.reference));
        if (out_data.ramp_done !== want.ramp_done)
          log_mismatch($sformatf("ramp_done mismatch: expected %0b got %0b",
                                 want.ramp_done, out_data.ramp_done));
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    ramp_ref       = '0;
    ramp_tgt       = '0;
    ramp_steps     = '0;
    ramp_incr      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_jumps();
    test_short_ramps();
    test_full_scale();
    test_random_ramps();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_refs.size() == 0) begin
      $display("linear_ramp_generator_top regression: pass");
    end else begin
      $display("linear_ramp_generator_top regression: fail");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("linear_ramp_generator_top regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lrg_pkg.sv
rtl/lrg_div.sv
rtl/linear_ramp_generator_top.sv
tb/sv/tb_linear_ramp_generator_top.sv
